// ----- rtl/qrs_pkg.sv -----
package qrs_pkg;

   // result field width, fixed by the result format
   localparam int OUT_WIDTH = 34;

   // root classification codes
   typedef enum logic [1:0] {
      KIND_REPEATED = 2'd0,
      KIND_TWO_REAL = 2'd1,
      KIND_COMPLEX  = 2'd2,
      KIND_INVALID  = 2'd3
   } kind_type;

endpackage

// ----- rtl/qrs_sqrt_cell.sv -----
// One digit step of the integer square root: retires one root bit per cell.
module qrs_sqrt_cell #(
   parameter int RAD_WIDTH = 66,
   parameter int SB_WIDTH  = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic [RAD_WIDTH-1:0]           in_rad,
   input  logic [RAD_WIDTH/2+2:0]         in_rem,
   input  logic [RAD_WIDTH/2-1:0]         in_root,
   input  logic [SB_WIDTH-1:0]            in_sb,
   output logic                           out_valid,
   output logic [RAD_WIDTH-1:0]           out_rad,
   output logic [RAD_WIDTH/2+2:0]         out_rem,
   output logic [RAD_WIDTH/2-1:0]         out_root,
   output logic [SB_WIDTH-1:0]            out_sb
);
   localparam int SW  = RAD_WIDTH / 2;
   localparam int RMW = SW + 3;

   logic                 valid_ff;
   logic [RAD_WIDTH-1:0] rad_ff, rad_in;
   logic [RMW-1:0]       rem_ff, rem_in;
   logic [SW-1:0]        root_ff, root_in;
   logic [SB_WIDTH-1:0]  sb_ff;
   logic [RMW-1:0]       shifted;
   logic [RMW-1:0]       trial;
   logic                 take;

   // bring in the next radicand bit pair and try the next root bit
   always_comb begin
      shifted = {in_rem[RMW-3:0], in_rad[RAD_WIDTH-1 -: 2]};
      trial   = {1'b0, in_root, 2'b01};
      take    = shifted >= trial;
      rem_in  = take ? shifted - trial : shifted;
      root_in = {in_root[SW-2:0], take};
      rad_in  = {in_rad[RAD_WIDTH-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         sb_ff   <= in_sb;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_sb    = sb_ff;
endmodule

// ----- rtl/qrs_div_cell.sv -----
// One restoring division step for two lanes sharing a divisor.
// Numerator shifts out at the top while quotient bits enter at the bottom.
module qrs_div_cell #(
   parameter int NUM_WIDTH = 35,
   parameter int DEN_WIDTH = 17,
   parameter int SB_WIDTH  = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [NUM_WIDTH-1:0]  in_num1,
   input  logic [NUM_WIDTH-1:0]  in_num2,
   input  logic [DEN_WIDTH:0]    in_rem1,
   input  logic [DEN_WIDTH:0]    in_rem2,
   input  logic [DEN_WIDTH-1:0]  in_den,
   input  logic [SB_WIDTH-1:0]   in_sb,
   output logic                  out_valid,
   output logic [NUM_WIDTH-1:0]  out_num1,
   output logic [NUM_WIDTH-1:0]  out_num2,
   output logic [DEN_WIDTH:0]    out_rem1,
   output logic [DEN_WIDTH:0]    out_rem2,
   output logic [DEN_WIDTH-1:0]  out_den,
   output logic [SB_WIDTH-1:0]   out_sb
);
   logic                 valid_ff;
   logic [NUM_WIDTH-1:0] num1_ff, num1_in, num2_ff, num2_in;
   logic [DEN_WIDTH:0]   rem1_ff, rem1_in, rem2_ff, rem2_in;
   logic [DEN_WIDTH-1:0] den_ff;
   logic [SB_WIDTH-1:0]  sb_ff;
   logic [DEN_WIDTH:0]   sh1, sh2, denx;
   logic                 ge1, ge2;

   // compare and subtract in both lanes
   always_comb begin
      denx    = {1'b0, in_den};
      sh1     = {in_rem1[DEN_WIDTH-1:0], in_num1[NUM_WIDTH-1]};
      sh2     = {in_rem2[DEN_WIDTH-1:0], in_num2[NUM_WIDTH-1]};
      ge1     = sh1 >= denx;
      ge2     = sh2 >= denx;
      rem1_in = ge1 ? sh1 - denx : sh1;
      rem2_in = ge2 ? sh2 - denx : sh2;
      num1_in = {in_num1[NUM_WIDTH-2:0], ge1};
      num2_in = {in_num2[NUM_WIDTH-2:0], ge2};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num1_ff <= num1_in;
         num2_ff <= num2_in;
         rem1_ff <= rem1_in;
         rem2_ff <= rem2_in;
         den_ff  <= in_den;
         sb_ff   <= in_sb;
      end
   end

   assign out_valid = valid_ff;
   assign out_num1  = num1_ff;
   assign out_num2  = num2_ff;
   assign out_rem1  = rem1_ff;
   assign out_rem2  = rem2_ff;
   assign out_den   = den_ff;
   assign out_sb    = sb_ff;
endmodule

// ----- rtl/quadratic_root_solver.sv -----
// Quadratic root solver: roots of a*x^2 + b*x + c = 0.
// Input channel req_*: one coefficient triple (coef_a, coef_b, coef_c) per beat,
// two's complement, COEF_WIDTH bits each.
// Result channel rsp_*: one beat per input beat, in order: root_kind plus
// first_value / second_value, signed fixed point with FRAC_BITS fraction bits.
// A zero coef_a gives root_kind invalid with both values zero.
// Pipeline: product and discriminant stages, SW = COEF_WIDTH+FRAC_BITS+1 square
// root cells, a numerator stage, QW = COEF_WIDTH+FRAC_BITS+3 divider cells, the
// output register. Throughput: one beat per cycle unless stalled; each root and
// divider cell retires one result bit and hands the item on each enabled cycle.
// Stall: the whole pipeline advances whenever the output register is empty or
// being taken; while rsp_stall holds a waiting result, req_stall is raised
// and every in-flight item holds its place.
// Reset: synchronous, clears all valid flags; no item is in flight afterward.
module quadratic_root_solver #(
   parameter int COEF_WIDTH = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [COEF_WIDTH-1:0]             req_coef_a,
   input  logic [COEF_WIDTH-1:0]             req_coef_b,
   input  logic [COEF_WIDTH-1:0]             req_coef_c,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_root_kind,
   output logic [qrs_pkg::OUT_WIDTH-1:0]     rsp_first_value,
   output logic [qrs_pkg::OUT_WIDTH-1:0]     rsp_second_value
);
   import qrs_pkg::*;

   localparam int W    = COEF_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int DW   = 2 * W + 2;          // discriminant magnitude
   localparam int RW   = DW + 2 * F;         // scaled radicand
   localparam int SW   = RW / 2;             // square root width
   localparam int RMW  = SW + 3;             // root remainder
   localparam int NBW  = W + F + 1;          // -b * 2^F
   localparam int DVW  = W + 1;              // |2a|
   localparam int QW   = W + F + 3;          // numerator / quotient
   localparam int SB1  = 2 + NBW + 1 + DVW;  // side data through root cells
   localparam int SB2  = 4;                  // side data through divide cells
   localparam int CW   = (QW > OUT_WIDTH) ? QW : OUT_WIDTH;

   logic en;

   // whole pipeline advances unless a finished beat is held
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // stage 1: magnitudes and products
   logic [W-1:0]    ua, ub, uc;
   logic [W:0]      bx;
   logic [W:0]      negb;
   logic            v1_ff;
   logic [2*W-1:0]  bb1_ff, p1_ff;
   logic            sdiff1_ff, az1_ff, dneg1_ff;
   logic [NBW-1:0]  nb1_ff;
   logic [DVW-1:0]  dmag1_ff;

   always_comb begin
      ua   = req_coef_a[W-1] ? W'(-req_coef_a) : req_coef_a;
      ub   = req_coef_b[W-1] ? W'(-req_coef_b) : req_coef_b;
      uc   = req_coef_c[W-1] ? W'(-req_coef_c) : req_coef_c;
      bx   = {req_coef_b[W-1], req_coef_b};
      negb = -bx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bb1_ff    <= ub * ub;
         p1_ff     <= ua * uc;
         sdiff1_ff <= req_coef_a[W-1] != req_coef_c[W-1];
         az1_ff    <= req_coef_a == '0;
         dneg1_ff  <= req_coef_a[W-1];
         nb1_ff    <= {negb, {F{1'b0}}};
         dmag1_ff  <= {ua, 1'b0};
      end
   end

   // stage 2: discriminant sign and magnitude
   logic [DW-1:0]  bbx, q4, m_in;
   kind_type       kind_in;
   logic           v2_ff;
   logic [DW-1:0]  m2_ff;
   logic [1:0]     kind2_ff;
   logic [NBW-1:0] nb2_ff;
   logic           dneg2_ff;
   logic [DVW-1:0] dmag2_ff;

   always_comb begin
      bbx = {2'b00, bb1_ff};
      q4  = {p1_ff, 2'b00};
      if (p1_ff == '0 || sdiff1_ff) begin
         m_in    = bbx + q4;
         kind_in = (m_in != '0) ? KIND_TWO_REAL : KIND_REPEATED;
      end else if (bbx >= q4) begin
         m_in    = bbx - q4;
         kind_in = (m_in != '0) ? KIND_TWO_REAL : KIND_REPEATED;
      end else begin
         m_in    = q4 - bbx;
         kind_in = KIND_COMPLEX;
      end
      if (az1_ff) begin
         kind_in = KIND_INVALID;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m2_ff    <= m_in;
         kind2_ff <= kind_in;
         nb2_ff   <= nb1_ff;
         dneg2_ff <= dneg1_ff;
         dmag2_ff <= dmag1_ff;
      end
   end

   // square root chain, one root bit per cell
   logic           sq_valid [0:SW];
   logic [RW-1:0]  sq_rad   [0:SW];
   logic [RMW-1:0] sq_rem   [0:SW];
   logic [SW-1:0]  sq_root  [0:SW];
   logic [SB1-1:0] sq_sb    [0:SW];

   assign sq_valid[0] = v2_ff;
   assign sq_rad[0]   = {m2_ff, {(2 * F){1'b0}}};
   assign sq_rem[0]   = '0;
   assign sq_root[0]  = '0;
   assign sq_sb[0]    = {kind2_ff, nb2_ff, dneg2_ff, dmag2_ff};

   for (genvar i = 0; i < SW; i++) begin : g_sqrt
      qrs_sqrt_cell #(
         .RAD_WIDTH(RW),
         .SB_WIDTH (SB1)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (sq_valid[i]),
         .in_rad   (sq_rad[i]),
         .in_rem   (sq_rem[i]),
         .in_root  (sq_root[i]),
         .in_sb    (sq_sb[i]),
         .out_valid(sq_valid[i+1]),
         .out_rad  (sq_rad[i+1]),
         .out_rem  (sq_rem[i+1]),
         .out_root (sq_root[i+1]),
         .out_sb   (sq_sb[i+1])
      );
   end

   // stage 3: numerators, their magnitudes and quotient signs
   logic [1:0]     kind_s;
   logic [NBW-1:0] nb_s;
   logic           dneg_s;
   logic [DVW-1:0] dmag_s;
   logic [QW-1:0]  nbx, sx, num1, num2, mag1_in, mag2_in;
   logic           v3_ff;
   logic [QW-1:0]  mag1_ff, mag2_ff;
   logic [DVW-1:0] den3_ff;
   logic [SB2-1:0] sb3_ff;

   always_comb begin
      {kind_s, nb_s, dneg_s, dmag_s} = sq_sb[SW];
      nbx = {{(QW - NBW){nb_s[NBW-1]}}, nb_s};
      sx  = {{(QW - SW){1'b0}}, sq_root[SW]};
      if (kind_s == KIND_COMPLEX) begin
         num1 = nbx;
         num2 = sx;
      end else begin
         num1 = nbx + sx;
         num2 = nbx - sx;
      end
      mag1_in = num1[QW-1] ? -num1 : num1;
      mag2_in = num2[QW-1] ? -num2 : num2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= sq_valid[SW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag1_ff <= mag1_in;
         mag2_ff <= mag2_in;
         den3_ff <= dmag_s;
         sb3_ff  <= {kind_s, num1[QW-1] ^ dneg_s, num2[QW-1] ^ dneg_s};
      end
   end

   // divider chain, one quotient bit per cell
   logic           dv_valid [0:QW];
   logic [QW-1:0]  dv_num1  [0:QW];
   logic [QW-1:0]  dv_num2  [0:QW];
   logic [DVW:0]   dv_rem1  [0:QW];
   logic [DVW:0]   dv_rem2  [0:QW];
   logic [DVW-1:0] dv_den   [0:QW];
   logic [SB2-1:0] dv_sb    [0:QW];

   assign dv_valid[0] = v3_ff;
   assign dv_num1[0]  = mag1_ff;
   assign dv_num2[0]  = mag2_ff;
   assign dv_rem1[0]  = '0;
   assign dv_rem2[0]  = '0;
   assign dv_den[0]   = den3_ff;
   assign dv_sb[0]    = sb3_ff;

   for (genvar j = 0; j < QW; j++) begin : g_div
      qrs_div_cell #(
         .NUM_WIDTH(QW),
         .DEN_WIDTH(DVW),
         .SB_WIDTH (SB2)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (dv_valid[j]),
         .in_num1  (dv_num1[j]),
         .in_num2  (dv_num2[j]),
         .in_rem1  (dv_rem1[j]),
         .in_rem2  (dv_rem2[j]),
         .in_den   (dv_den[j]),
         .in_sb    (dv_sb[j]),
         .out_valid(dv_valid[j+1]),
         .out_num1 (dv_num1[j+1]),
         .out_num2 (dv_num2[j+1]),
         .out_rem1 (dv_rem1[j+1]),
         .out_rem2 (dv_rem2[j+1]),
         .out_den  (dv_den[j+1]),
         .out_sb   (dv_sb[j+1])
      );
   end

   // apply sign and clamp to the result range
   localparam logic [CW:0] LIM_POS = (CW + 1)'((64'd1 << (OUT_WIDTH - 1)) - 64'd1);
   localparam logic [CW:0] LIM_NEG = (CW + 1)'(64'd1 << (OUT_WIDTH - 1));

   function automatic logic [OUT_WIDTH-1:0] clamp(input logic [QW-1:0] mag,
                                                  input logic neg);
      logic [CW:0] mx;
      logic [CW:0] nx;
      mx = (CW + 1)'(mag);
      nx = -mx;
      if (neg) begin
         clamp = (mx > LIM_NEG) ? {1'b1, {(OUT_WIDTH - 1){1'b0}}} : nx[OUT_WIDTH-1:0];
      end else begin
         clamp = (mx > LIM_POS) ? {1'b0, {(OUT_WIDTH - 1){1'b1}}} : mx[OUT_WIDTH-1:0];
      end
   endfunction

   logic [1:0]           kind_o;
   logic                 neg1_o, neg2_o;
   logic [OUT_WIDTH-1:0] first_in, second_in;
   logic                 rsp_valid_ff;
   logic [1:0]           kind_ff;
   logic [OUT_WIDTH-1:0] first_ff, second_ff;

   always_comb begin
      {kind_o, neg1_o, neg2_o} = dv_sb[QW];
      if (kind_o == KIND_INVALID) begin
         first_in  = '0;
         second_in = '0;
      end else begin
         first_in  = clamp(dv_num1[QW], neg1_o);
         second_in = clamp(dv_num2[QW], neg2_o);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind_ff   <= kind_o;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_root_kind    = kind_ff;
   assign rsp_first_value  = first_ff;
   assign rsp_second_value = second_ff;
endmodule

// ----- tb/quadratic_root_solver_test.sv -----
module quadratic_root_solver_test;
   import qrs_pkg::*;

   localparam int CW = 16;
   localparam int FB = 16;
   localparam int LATENCY = 72;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [CW-1:0] req_coef_a = '0;
   logic [CW-1:0] req_coef_b = '0;
   logic [CW-1:0] req_coef_c = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_root_kind;
   logic [OUT_WIDTH-1:0] rsp_first_value;
   logic [OUT_WIDTH-1:0] rsp_second_value;

   typedef struct packed {
      kind_type kind;
      logic [OUT_WIDTH-1:0] first;
      logic [OUT_WIDTH-1:0] second;
   } roots_type;

   roots_type expected_roots[$];
   int mismatches = 0;
   bit quiet_send = 1'b0;   // when set, the sender never idles
   bit quiet_take = 1'b0;   // when set, the receiver never stalls

   quadratic_root_solver #(.COEF_WIDTH(CW), .FRAC_BITS(FB)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_coef_a(req_coef_a), .req_coef_b(req_coef_b), .req_coef_c(req_coef_c),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_root_kind(rsp_root_kind), .rsp_first_value(rsp_first_value),
      .rsp_second_value(rsp_second_value)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // floor square root of a 128-bit value, one bit per pass
   function automatic logic [63:0] root_floor(logic [127:0] n);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         t = r | (64'd1 << i);
         if ({64'd0, t} * {64'd0, t} <= n) r = t;
      end
      return r;
   endfunction

   // clamp to the signed result range
   function automatic logic [OUT_WIDTH-1:0] clamp_out(logic signed [127:0] v);
      logic signed [127:0] hi;
      logic signed [127:0] lo;
      hi = (128'sd1 <<< (OUT_WIDTH-1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[OUT_WIDTH-1:0];
   endfunction

   // roots of a*x^2 + b*x + c in fixed point
   function automatic roots_type solve_roots(logic [CW-1:0] ra, logic [CW-1:0] rb,
                                             logic [CW-1:0] rc);
      logic signed [127:0] a, b, c, disc, mag, nb, d, v1, v2, s;
      roots_type r;
      a = $signed(ra);
      b = $signed(rb);
      c = $signed(rc);
      if (a == 0) begin
         r.kind = KIND_INVALID;
         r.first = '0;
         r.second = '0;
         return r;
      end
      disc = b * b - 4 * a * c;
      mag = disc < 0 ? -disc : disc;
      s = $signed({64'd0, root_floor(mag << (2 * FB))});
      nb = -b * (128'sd1 <<< FB);
      d = 2 * a;
      // signed division in SV truncates toward zero
      if (disc == 0) begin
         r.kind = KIND_REPEATED;
         v1 = nb / d;
         v2 = v1;
      end else if (disc > 0) begin
         r.kind = KIND_TWO_REAL;
         v1 = (nb + s) / d;
         v2 = (nb - s) / d;
      end else begin
         r.kind = KIND_COMPLEX;
         v1 = nb / d;
         v2 = s / d;
      end
      r.first = clamp_out(v1);
      r.second = clamp_out(v2);
      return r;
   endfunction

   // send one triple; holds until accepted, valid stays up for a following beat
   task automatic send_coefs(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c);
      while (!quiet_send && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_coef_a <= a;
      req_coef_b <= b;
      req_coef_c <= c;
      expected_roots.push_back(solve_roots(a, b, c));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !quiet_take && ($urandom_range(99) < 29);
      end
   end

   // result checker
   always @(posedge clock) begin
      roots_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_roots.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat kind %0d", rsp_root_kind);
         end else begin
            want = expected_roots.pop_front();
            if (rsp_root_kind !== want.kind || rsp_first_value !== want.first ||
                rsp_second_value !== want.second) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: want kind %0d %h %h, got kind %0d %h %h",
                           want.kind, want.first, want.second, rsp_root_kind,
                           rsp_first_value, rsp_second_value);
            end
         end
      end
   end

   task automatic test_extremes();
      logic [CW-1:0] ends[4];
      ends = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
      foreach (ends[i]) send_coefs(ends[i], ends[(i+1)%4], ends[(i+2)%4]);
      send_coefs(16'h8000, 16'h8000, 16'h7fff);
      send_coefs(16'h7fff, 16'h8000, 16'h8000);
      send_coefs(16'h8000, 16'h7fff, 16'h8000);
      send_coefs(16'h0001, 16'h0000, 16'h0000);
   endtask

   task automatic test_root_kinds();
      send_coefs(16'd1, -16'sd4, 16'd4);      // repeated root
      send_coefs(-16'sd3, 16'd12, -16'sd12);  // repeated root, negative a
      send_coefs(16'd1, -16'sd3, 16'd2);      // two real roots
      send_coefs(-16'sd2, 16'd1, 16'd5);      // two real, negative a
      send_coefs(16'd1, 16'd2, 16'd5);        // complex pair
      send_coefs(-16'sd1, 16'd2, -16'sd5);    // complex pair, negative a
      send_coefs(16'd0, 16'd5, 16'd7);        // zero a
      send_coefs(16'd0, 16'hffff, 16'h8000);
      send_coefs(16'd7, 16'd0, 16'd0);
   endtask

   task automatic test_random(int count);
      logic [CW-1:0] a, b, c, r;
      for (int i = 0; i < count; i++) begin
         quiet_send = (i >= count / 2) && (i < count / 2 + 150);
         quiet_take = quiet_send;
         a = CW'($urandom);
         b = CW'($urandom);
         c = CW'($urandom);
         case ($urandom_range(9))
            0: a = '0;
            1: begin  // perfect square, repeated root
               r = CW'($urandom_range(1, 30));
               a = CW'($urandom_range(1, 12));
               if ($urandom_range(1)) a = -a;
               b = CW'(2 * a * r);
               c = CW'(a * r * r);
            end
            2: begin  // small coefficients
               a = CW'($signed(4'($urandom)));
               b = CW'($signed(4'($urandom)));
               c = CW'($signed(4'($urandom)));
            end
            default: ;
         endcase
         send_coefs(a, b, c);
      end
      quiet_send = 1'b0;
      quiet_take = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_root_kinds();
      test_random(1250);
      req_valid <= 1'b0;
      while (expected_roots.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && expected_roots.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end
endmodule
